// File: rtl/mucodec_pkg.sv
// ----------------------------------------------------------------------------
// mucodec_pkg
// Shared types and constants for the Manchester-over-UART codec.
// ----------------------------------------------------------------------------
package mucodec_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CODE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_XMIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX_CODE = 2'd0,
    KIND_RX_DATA = 2'd1,
    KIND_FINISH  = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CODE_ERR = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  localparam logic [7:0]  GAP_TIMEOUT_RST = 8'd3;
  localparam logic [15:0] PAIR_MASK       = 16'h5555;
  localparam int unsigned FIFO_DEPTH      = 4;
  localparam int unsigned FIFO_AW         = $clog2(FIFO_DEPTH);

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    status_e     status;
    logic [15:0] count;
    logic        last;
  } result_t;

  // Up to two results produced by one item
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

  // Data bit i -> code bits 2i+1..2i: 0 -> 10, 1 -> 01
  function automatic logic [7:0] encode_nibble(input logic [3:0] nib);
    logic [7:0] code;
    code = '0;
    for (int i = 0; i < 4; i++) begin
      code[2*i]   = nib[i];
      code[2*i+1] = ~nib[i];
    end
    return code;
  endfunction

  function automatic logic [7:0] decode_word(input logic [15:0] word);
    logic [7:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      v[i] = word[2*i];
    end
    return v;
  endfunction

endpackage

// File: rtl/mucodec_core.sv
// ----------------------------------------------------------------------------
// mucodec_core
// Input register, receive session state and single-pass result logic.
// ----------------------------------------------------------------------------
module mucodec_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic [7:0]           data_i,
  input  logic [15:0]          byte_count_i,
  input  logic [15:0]          first_timeout_i,
  input  logic                 room_i,
  output mucodec_pkg::push_t   push_o
);
  import mucodec_pkg::*;

  logic        in_vld_q;
  op_e         op_q;
  logic [7:0]  data_q;
  logic [15:0] cnt_q;
  logic [15:0] first_q;

  logic [7:0]  gap_q;
  logic        active_q, active_d;
  logic        await_q, await_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] recv_q, recv_d;
  logic [15:0] ticks_q, ticks_d;

  logic        fire;
  logic        in_acc;
  logic [15:0] word;
  logic [15:0] recv_inc;
  logic [15:0] remain_dec;
  push_t       push;

  assign fire       = in_vld_q && room_i;
  assign in_stall_o = in_vld_q && !room_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign word       = {data_q, low_q};
  assign recv_inc   = recv_q + 16'd1;
  assign remain_dec = remain_q - 16'd1;

  function automatic result_t mk_res(kind_e k, logic [7:0] d, status_e s,
                                     logic [15:0] c, logic l);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.status = s;
    r.count  = c;
    r.last   = l;
    return r;
  endfunction

  always_comb begin
    active_d = active_q;
    await_d  = await_q;
    low_d    = low_q;
    remain_d = remain_q;
    recv_d   = recv_q;
    ticks_d  = ticks_q;
    push.num  = 2'd0;
    push.res0 = mk_res(KIND_TX_CODE, 8'd0, ST_OK, 16'd0, 1'b1);
    push.res1 = mk_res(KIND_TX_CODE, 8'd0, ST_OK, 16'd0, 1'b1);
    if (fire) begin
      unique case (op_q)
        OP_START: begin
          active_d = (cnt_q != 16'd0);
          await_d  = 1'b0;
          low_d    = 8'd0;
          remain_d = cnt_q;
          recv_d   = 16'd0;
          ticks_d  = first_q;
          if (cnt_q == 16'd0) begin
            push.num  = 2'd1;
            push.res0 = mk_res(KIND_FINISH, 8'd0, ST_OK, 16'd0, 1'b1);
          end
        end
        OP_CODE: begin
          if (active_q) begin
            ticks_d = {8'd0, gap_q};
            if (!await_q) begin
              low_d   = data_q;
              await_d = 1'b1;
            end else begin
              await_d = 1'b0;
              if (((word ^ (word >> 1)) & PAIR_MASK) != PAIR_MASK) begin
                active_d  = 1'b0;
                push.num  = 2'd1;
                push.res0 = mk_res(KIND_FINISH, 8'd0, ST_CODE_ERR, 16'd0, 1'b1);
              end else begin
                recv_d   = recv_inc;
                remain_d = remain_dec;
                if (remain_dec == 16'd0) begin
                  active_d  = 1'b0;
                  push.num  = 2'd2;
                  push.res0 = mk_res(KIND_RX_DATA, decode_word(word), ST_OK, 16'd0, 1'b0);
                  push.res1 = mk_res(KIND_FINISH, 8'd0, ST_OK, recv_inc, 1'b1);
                end else begin
                  push.num  = 2'd1;
                  push.res0 = mk_res(KIND_RX_DATA, decode_word(word), ST_OK, 16'd0, 1'b1);
                end
              end
            end
          end
        end
        OP_TICK: begin
          if (active_q) begin
            if (ticks_q <= 16'd1) begin
              ticks_d   = 16'd0;
              active_d  = 1'b0;
              await_d   = 1'b0;
              push.num  = 2'd1;
              push.res0 = mk_res(KIND_FINISH, 8'd0, ST_TIMEOUT, recv_q, 1'b1);
            end else begin
              ticks_d = ticks_q - 16'd1;
            end
          end
        end
        OP_XMIT: begin
          push.num  = 2'd2;
          push.res0 = mk_res(KIND_TX_CODE, encode_nibble(data_q[3:0]), ST_OK, 16'd0, 1'b0);
          push.res1 = mk_res(KIND_TX_CODE, encode_nibble(data_q[7:4]), ST_OK, 16'd0, 1'b1);
        end
        default: ;
      endcase
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      gap_q    <= GAP_TIMEOUT_RST;
      active_q <= 1'b0;
      await_q  <= 1'b0;
      low_q    <= 8'd0;
      remain_q <= 16'd0;
      recv_q   <= 16'd0;
      ticks_q  <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      active_q <= active_d;
      await_q  <= await_d;
      low_q    <= low_d;
      remain_q <= remain_d;
      recv_q   <= recv_d;
      ticks_q  <= ticks_d;
    end
  end

  // Payload of the input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_e'(operation_i);
      data_q  <= data_i;
      cnt_q   <= byte_count_i;
      first_q <= first_timeout_i;
    end
  end

endmodule

// File: rtl/mucodec_res_fifo.sv
// ----------------------------------------------------------------------------
// mucodec_res_fifo
// Small result queue: takes up to two results a cycle, sends one beat a cycle unless stalled.
// ----------------------------------------------------------------------------
module mucodec_res_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mucodec_pkg::push_t    push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mucodec_pkg::result_t  head_o
);
  import mucodec_pkg::*;

  localparam int unsigned CW = FIFO_AW + 1;

  result_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]        cnt_q;
  logic                 pop;
  logic [FIFO_AW-1:0]   wr_nxt;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= CW'(FIFO_DEPTH - 2));
  assign head_o      = mem_q[rd_q];
  assign wr_nxt      = wr_q + FIFO_AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FIFO_AW'(push_i.num);
      rd_q  <= rd_q + FIFO_AW'(pop);
      cnt_q <= cnt_q + CW'(push_i.num) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_nxt] <= push_i.res1;
    end
  end

endmodule

// File: rtl/manchester_uart_codec_top.sv
// ----------------------------------------------------------------------------
// manchester_uart_codec_top
// Manchester codec over byte-wide UART code words: transmit encode and
// receive session decode with tick-based timeouts.
// ----------------------------------------------------------------------------
// Path: an accepted beat is held in the input register, then processed into
//   the result queue once it has room; result beats leave from the queue head.
// Throughput: one input beat per cycle for items with zero or one result while
//   the output is not stalled; two-result items (transmit, final byte) are limited
//   by the single output beat per cycle drained from the 4-entry result queue.
// Reset: rst_ni async, active low; clears session state, queue and sets
//   gap_timeout to 3.
module manchester_uart_codec_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_i,
  input  logic [15:0] byte_count_i,
  input  logic [15:0] first_timeout_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_res_o,
  output logic [1:0]  status_o,
  output logic [15:0] received_count_o,
  output logic        last_o
);
  import mucodec_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  mucodec_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .data_i          (data_i),
    .byte_count_i    (byte_count_i),
    .first_timeout_i (first_timeout_i),
    .room_i          (room),
    .push_o          (push)
  );

  mucodec_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o           = head.kind;
  assign data_res_o       = head.data;
  assign status_o         = head.status;
  assign received_count_o = head.count;
  assign last_o           = head.last;

endmodule

// File: verif/manchester_uart_codec_checker.sv
// ----------------------------------------------------------------------------
// manchester_uart_codec_checker
// Watches both channels and the gap timeout register of the codec. It keeps
// its own copy of the receive session state, works out the result beats
// that each accepted input beat must cause, and compares every output beat
// field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module manchester_uart_codec_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_i,
  input  logic [15:0] byte_count_i,
  input  logic [15:0] first_timeout_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_res_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] received_count_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned due_count_o,
  output int unsigned checked_count_o,
  output int unsigned ok_count_o,
  output int unsigned err_count_o,
  output int unsigned tmo_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mucodec_pkg::*;

  result_t     results_due[$];

  // receive session copy
  logic        rx_open;
  logic        have_low;
  logic [7:0]  low_byte;
  logic [15:0] bytes_left;
  logic [15:0] bytes_got;
  logic [15:0] ticks_left;
  logic [7:0]  gap_ticks;

  int unsigned mismatches;
  int unsigned beats_checked;
  int unsigned finished_ok;
  int unsigned finished_err;
  int unsigned finished_tmo;

  function automatic logic [7:0] line_code(input logic [3:0] nib);
    logic [7:0] code;
    code = '0;
    for (int i = 0; i < 4; i++) begin
      code[2*i +: 2] = nib[i] ? 2'b01 : 2'b10;
    end
    return code;
  endfunction

  function automatic result_t beat_of(input kind_e k, input logic [7:0] d,
                                      input status_e s, input logic [15:0] c,
                                      input logic l);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.status = s;
    r.count  = c;
    r.last   = l;
    return r;
  endfunction

  task automatic absorb_item(input logic [1:0] op_bits, input logic [7:0] d,
                             input logic [15:0] cnt, input logic [15:0] first);
    logic [15:0] word;
    logic [7:0]  plain;
    case (op_e'(op_bits))
      OP_START: begin
        rx_open    = 1'b1;
        have_low   = 1'b0;
        low_byte   = '0;
        bytes_left = cnt;
        bytes_got  = '0;
        ticks_left = first;
        if (cnt == '0) begin
          rx_open = 1'b0;
          results_due.push_back(beat_of(KIND_FINISH, 8'h00, ST_OK, 16'h0000, 1'b1));
        end
      end
      OP_CODE: begin
        if (rx_open) begin
          ticks_left = {8'h00, gap_ticks};
          if (!have_low) begin
            low_byte = d;
            have_low = 1'b1;
          end else begin
            word     = {d, low_byte};
            have_low = 1'b0;
            if (((word ^ (word >> 1)) & PAIR_MASK) != PAIR_MASK) begin
              rx_open = 1'b0;
              results_due.push_back(beat_of(KIND_FINISH, 8'h00, ST_CODE_ERR, 16'h0000, 1'b1));
            end else begin
              for (int i = 0; i < 8; i++) begin
                plain[i] = word[2*i];
              end
              bytes_got  = bytes_got + 16'd1;
              bytes_left = bytes_left - 16'd1;
              if (bytes_left == '0) begin
                rx_open = 1'b0;
                results_due.push_back(beat_of(KIND_RX_DATA, plain, ST_OK, 16'h0000, 1'b0));
                results_due.push_back(beat_of(KIND_FINISH, 8'h00, ST_OK, bytes_got, 1'b1));
              end else begin
                results_due.push_back(beat_of(KIND_RX_DATA, plain, ST_OK, 16'h0000, 1'b1));
              end
            end
          end
        end
      end
      OP_TICK: begin
        if (rx_open) begin
          // a timeout of 0 behaves like 1
          if (ticks_left <= 16'd1) begin
            ticks_left = '0;
            rx_open    = 1'b0;
            have_low   = 1'b0;
            results_due.push_back(beat_of(KIND_FINISH, 8'h00, ST_TIMEOUT, bytes_got, 1'b1));
          end else begin
            ticks_left = ticks_left - 16'd1;
          end
        end
      end
      default: begin
        results_due.push_back(beat_of(KIND_TX_CODE, line_code(d[3:0]), ST_OK, 16'h0000, 1'b0));
        results_due.push_back(beat_of(KIND_TX_CODE, line_code(d[7:4]), ST_OK, 16'h0000, 1'b1));
      end
    endcase
  endtask

  task automatic check_result();
    result_t want;
    if (results_due.size() == 0) begin
      $error("result beat with nothing outstanding: kind %0d data %0h", kind_i, data_res_i);
      mismatches++;
    end else begin
      want = results_due.pop_front();
      beats_checked++;
      if (want.kind == KIND_FINISH) begin
        case (want.status)
          ST_OK:       finished_ok++;
          ST_CODE_ERR: finished_err++;
          default:     finished_tmo++;
        endcase
      end
      if (kind_i !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind_i);
        mismatches++;
      end
      if (data_res_i !== want.data) begin
        $error("data_res: expected %0h, got %0h", want.data, data_res_i);
        mismatches++;
      end
      if (status_i !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status_i);
        mismatches++;
      end
      if (received_count_i !== want.count) begin
        $error("received_count: expected %0d, got %0d", want.count, received_count_i);
        mismatches++;
      end
      if (last_i !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last_i);
        mismatches++;
      end
    end
  endtask

  initial begin
    mismatches    = 0;
    beats_checked = 0;
    finished_ok   = 0;
    finished_err  = 0;
    finished_tmo  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_open    = 1'b0;
      have_low   = 1'b0;
      low_byte   = '0;
      bytes_left = '0;
      bytes_got  = '0;
      ticks_left = '0;
      gap_ticks  = GAP_TIMEOUT_RST;
      results_due.delete();
    end else begin
      if (cfg_we_i) begin
        gap_ticks = cfg_wdata_i;
      end
      // output side first so a beat cannot match work taken in this same edge
      if (out_valid_i && !out_stall_i) begin
        check_result();
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_item(operation_i, data_i, byte_count_i, first_timeout_i);
      end
    end
    fail_count_o    <= mismatches;
    due_count_o     <= results_due.size();
    checked_count_o <= beats_checked;
    ok_count_o      <= finished_ok;
    err_count_o     <= finished_err;
    tmo_count_o     <= finished_tmo;
  end

endmodule

// File: verif/manchester_uart_codec_top_tb.sv
// ----------------------------------------------------------------------------
// manchester_uart_codec_top_tb
// Drives transmit bytes, receive sessions, code bytes and ticks into the
// codec under random idling on both channels and several gap timeout
// settings; the checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module manchester_uart_codec_top_tb;
  import mucodec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT      = 1000;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned ITEMS_PER_PHASE = 230;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [7:0]  data_i;
  logic [15:0] byte_count_i;
  logic [15:0] first_timeout_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  data_res_o;
  logic [1:0]  status_o;
  logic [15:0] received_count_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned checked_count;
  int unsigned ok_count;
  int unsigned err_count;
  int unsigned tmo_count;

  int unsigned beats_sent;
  int unsigned settings_used;
  logic [7:0]  gap_now;
  bit          quiet;
  bit          no_gaps;
  bit          tx_idle_on;
  bit          hold_req;
  bit          hold_done;

  manchester_uart_codec_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .data_i           (data_i),
    .byte_count_i     (byte_count_i),
    .first_timeout_i  (first_timeout_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_res_o       (data_res_o),
    .status_o         (status_o),
    .received_count_o (received_count_o),
    .last_o           (last_o)
  );

  manchester_uart_codec_checker codec_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .operation_i      (operation_i),
    .data_i           (data_i),
    .byte_count_i     (byte_count_i),
    .first_timeout_i  (first_timeout_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_i           (kind_o),
    .data_res_i       (data_res_o),
    .status_i         (status_o),
    .received_count_i (received_count_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .due_count_o      (due_count),
    .checked_count_o  (checked_count),
    .ok_count_o       (ok_count),
    .err_count_o      (err_count),
    .tmo_count_o      (tmo_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] code_for_nibble(input logic [3:0] nib);
    logic [7:0] code;
    code = '0;
    for (int i = 0; i < 4; i++) begin
      code[2*i]   = nib[i];
      code[2*i+1] = ~nib[i];
    end
    return code;
  endfunction

  // one input beat; valid stays up unless a random gap follows
  task automatic put_beat(input op_e op, input logic [7:0] d,
                          input logic [15:0] cnt, input logic [15:0] first);
    operation_i     <= op;
    data_i          <= d;
    byte_count_i    <= cnt;
    first_timeout_i <= first;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (!quiet && !no_gaps && tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic stray_ticks();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      n = 0;
    end else if (r < 19) begin
      n = $urandom_range(1, 2);
    end else begin
      // enough ticks to run out a gap timeout of 8 or less; two otherwise
      n = (gap_now <= 8'd8) ? gap_now + 1 : 2;
    end
    repeat (n) put_beat(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic code_pair(input logic [7:0] d, input bit spoil, input bit loose);
    logic [15:0] word;
    word = {code_for_nibble(d[7:4]), code_for_nibble(d[3:0])};
    // a single flipped bit always breaks its bit pair
    if (spoil) word[$urandom_range(0, 15)] ^= 1'b1;
    put_beat(OP_CODE, word[7:0], 16'($urandom), 16'($urandom));
    if (loose) stray_ticks();
    put_beat(OP_CODE, word[15:8], 16'($urandom), 16'($urandom));
    if (loose) stray_ticks();
  endtask

  task automatic rx_session();
    logic [15:0] cnt;
    logic [15:0] first;
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 9);
    if (r == 0) cnt = 16'd0;
    else if (r < 8) cnt = 16'($urandom_range(1, 5));
    else if (r == 8) cnt = 16'($urandom);
    else cnt = 16'hFFFF;
    first = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    tx_idle_on = ($urandom_range(0, 2) != 0);
    put_beat(OP_START, 8'($urandom), cnt, first);
    n = (cnt > 16'd6) ? $urandom_range(1, 6) : cnt;
    repeat ($urandom_range(0, 2)) put_beat(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        put_beat(OP_XMIT, 8'($urandom), 16'($urandom), 16'($urandom));
      end
      // left open; the next start drops it
      if ($urandom_range(0, 15) == 0) return;
      code_pair(8'($urandom), $urandom_range(0, 15) == 0, 1'b1);
    end
  endtask

  task automatic mixed_traffic(input int unsigned target);
    int unsigned stop_at;
    int unsigned r;
    stop_at = beats_sent + target;
    while (beats_sent < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        rx_session();
      end else if (r < 9) begin
        put_beat(OP_XMIT, 8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        put_beat(op_e'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                 16'($urandom));
      end
    end
  endtask

  task automatic directed();
    put_beat(OP_XMIT, 8'h00, 16'h0000, 16'h0000);
    put_beat(OP_XMIT, 8'hFF, 16'hFFFF, 16'hFFFF);
    put_beat(OP_XMIT, 8'h5A, 16'h1234, 16'h8001);
    // nothing open: tick and code byte are dropped
    put_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    put_beat(OP_CODE, 8'h55, 16'h0000, 16'h0000);
    // zero byte count closes at once
    put_beat(OP_START, 8'h00, 16'd0, 16'd0);
    // zero first timeout still takes a code byte ahead of the first tick
    put_beat(OP_START, 8'h00, 16'd2, 16'd0);
    code_pair(8'h3C, 1'b0, 1'b0);
    code_pair(8'hE1, 1'b0, 1'b0);
    put_beat(OP_START, 8'h00, 16'd1, 16'd2);
    repeat (2) put_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    // timeout with a low code byte held: the half pair does not count
    put_beat(OP_START, 8'h00, 16'd3, 16'd5);
    code_pair(8'h96, 1'b0, 1'b0);
    put_beat(OP_CODE, 8'hA9, 16'h0000, 16'h0000);
    repeat (3) put_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    // restart drops the open session; transmit leaves it alone
    put_beat(OP_START, 8'hFF, 16'hFFFF, 16'hFFFF);
    put_beat(OP_START, 8'h00, 16'd1, 16'd9);
    put_beat(OP_XMIT, 8'h96, 16'h0000, 16'h0000);
    put_beat(OP_CODE, 8'h00, 16'h0000, 16'h0000);
    put_beat(OP_CODE, 8'h00, 16'h0000, 16'h0000);
  endtask

  // drain everything outstanding, then let ticks and half pairs settle
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_gap(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    gap_now = value;
    settings_used++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [7:0] gap_plan [5];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 8'h00;
    in_valid_i      = 1'b0;
    operation_i     = OP_START;
    data_i          = 8'h00;
    byte_count_i    = 16'h0000;
    first_timeout_i = 16'h0000;
    quiet           = 1'b0;
    no_gaps         = 1'b0;
    tx_idle_on      = 1'b1;
    hold_req        = 1'b0;
    beats_sent      = 0;
    settings_used   = 1;
    gap_now         = GAP_TIMEOUT_RST;
    gap_plan        = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd3};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    mixed_traffic(ITEMS_PER_PHASE);
    for (int p = 0; p < 5; p++) begin
      settle();
      write_gap(gap_plan[p]);
      if (p == 1) begin
        // output held off while transmit beats keep coming
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (20) put_beat(OP_XMIT, 8'($urandom), 16'($urandom), 16'($urandom));
        no_gaps  = 1'b0;
      end
      if (p == 4) quiet = 1'b1;
      mixed_traffic(ITEMS_PER_PHASE);
    end
    settle();

    $display("Sent %0d input beats under %0d gap timeout settings; %0d result beats checked.",
             beats_sent, settings_used, checked_count);
    $display("Receive sessions closed: %0d ok, %0d code error, %0d timeout.",
             ok_count, err_count, tmo_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: manchester_uart_codec_top.f
rtl/mucodec_pkg.sv
rtl/mucodec_core.sv
rtl/mucodec_res_fifo.sv
rtl/manchester_uart_codec_top.sv
verif/manchester_uart_codec_checker.sv
verif/manchester_uart_codec_top_tb.sv
